// File: hdl/binom_pkg.sv
package binom_pkg;

	localparam int unsigned N_W    = 10;
	localparam int unsigned COEF_W = 30;
	localparam int unsigned SUM_W  = COEF_W + 1;

	localparam logic [SUM_W-1:0] PRIME = SUM_W'(1000000007);

	// one-hot sequencer states
	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_SWEEP  = 5'b00010,
		ST_FETCH  = 5'b00100,
		ST_LOAD   = 5'b01000,
		ST_RESULT = 5'b10000
	} state_t;

	// modular add, operands below the prime
	function automatic logic [COEF_W-1:0] mod_add(input logic [COEF_W-1:0] a,
		input logic [COEF_W-1:0] b);
		logic [SUM_W-1:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= PRIME) begin
			s = s - PRIME;
		end
		return s[COEF_W-1:0];
	endfunction

endpackage

// File: hdl/binom_ram.sv
module binom_ram #(
	parameter int unsigned WIDTH = 30,
	parameter int unsigned DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

// File: hdl/binomial_coefficient_mod_prime_top.sv
// Binomial coefficient C(n, k) mod 1000000007 by Pascal's rule. Each query
// rebuilds one row buffer, held in a single simple dual-port RAM of MAX_N+1
// entries (30 bits, registered read), in place from row 2 up to row n; rows 0
// and 1 and every edge entry are known to be 1 and are never stored. The sweep
// over a row walks downward, one RAM read and one write-back per cycle: the
// entry above-right is carried in a register, so each modular add needs only
// one read. A query with 1 <= k < n runs the sweep, then ST_FETCH for the
// final lookup read and ST_LOAD for the result register, before ST_RESULT
// hands the coefficient to the output register; a query with k = 0, k = n,
// k > n or n > MAX_N needs no sweep and goes from ST_IDLE straight to
// ST_RESULT. One query is worked at a time; the next transaction is taken as
// soon as the sequencer is idle, even while the previous result is still
// waiting in the output register on the master side. A finished result only
// waits while that register is still full. The RAM needs no clearing after
// reset, since a query reads only entries it has written itself.
module binomial_coefficient_mod_prime_top #(
	parameter int unsigned MAX_N = 1023
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // [9:0] row_n, [19:10] choose_k, rest zero
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata    // [29:0] coefficient, rest zero
);

	localparam int unsigned DEPTH = MAX_N + 1;
	localparam int unsigned AW    = $clog2(DEPTH);

	localparam int unsigned NW = binom_pkg::N_W;
	localparam int unsigned CW = binom_pkg::COEF_W;

	binom_pkg::state_t state_q;

	logic [NW-1:0] n_q, k_q;     // query
	logic [NW-1:0] i_q;          // row being built
	logic [NW-1:0] r_q;          // read index within the row
	logic [CW-1:0] held_q;       // old value of the entry being written
	logic [CW-1:0] res_q;
	logic [CW-1:0] out_q;        // result held on the master side

	// read-return stage
	logic          v_s1;
	logic [NW-1:0] idx_s1;       // entry to write back
	logic          first_s1;     // first step of a row: upper entry is an edge
	logic          zero_s1;      // lower entry is entry 0
	logic          fwd_s1;       // read collided with a write
	logic [CW-1:0] fwdd_s1;

	logic          wr_en;
	logic [AW-1:0] wr_addr, rd_addr;
	logic [CW-1:0] wr_data, ram_q, rd_val, lower, upper;
	logic          issue_first;
	logic          out_load;     // finished result moves into the output register

	binom_ram #(
		.WIDTH(CW),
		.DEPTH(DEPTH)
	) u_row (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_addr(rd_addr),
		.rd_data(ram_q)
	);

	// read data with bypass of a write to the same entry in the read cycle
	assign rd_val  = fwd_s1 ? fwdd_s1 : ram_q;
	assign lower   = zero_s1 ? CW'(1) : rd_val;
	assign upper   = first_s1 ? CW'(1) : held_q;
	assign wr_en   = v_s1;
	assign wr_addr = AW'(idx_s1);
	assign wr_data = binom_pkg::mod_add(upper, lower);
	assign rd_addr = (state_q == binom_pkg::ST_SWEEP) ? AW'(r_q) : AW'(k_q);

	assign issue_first = ({1'b0, r_q} + (NW+1)'(2)) == {1'b0, i_q};

	assign out_load = (state_q == binom_pkg::ST_RESULT) && (!m_tvalid || m_tready);

	assign s_tready = (state_q == binom_pkg::ST_IDLE);
	assign m_tdata  = {2'b00, out_q};

	// read-return stage and carried entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= (state_q == binom_pkg::ST_SWEEP);
		end
	end

	always_ff @(posedge clk) begin
		idx_s1   <= r_q + NW'(1);
		first_s1 <= issue_first;
		zero_s1  <= (r_q == '0);
		fwd_s1   <= wr_en && (wr_addr == rd_addr);
		fwdd_s1  <= wr_data;
		if (v_s1) begin
			held_q <= lower;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= binom_pkg::ST_IDLE;
			m_tvalid <= 1'b0;
		end else begin
			if (out_load) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
			unique case (state_q)
				binom_pkg::ST_IDLE: begin
					if (s_tvalid) begin
						if (s_tdata[19:10] > s_tdata[9:0]
							|| 32'(s_tdata[9:0]) > 32'(MAX_N)) begin
							state_q <= binom_pkg::ST_RESULT;
						end else if (s_tdata[19:10] == '0
							|| s_tdata[19:10] == s_tdata[9:0]) begin
							state_q <= binom_pkg::ST_RESULT;
						end else begin
							state_q <= binom_pkg::ST_SWEEP;
						end
					end
				end
				binom_pkg::ST_SWEEP: begin
					if (r_q == '0 && i_q == n_q) begin
						state_q <= binom_pkg::ST_FETCH;
					end
				end
				binom_pkg::ST_FETCH: begin
					state_q <= binom_pkg::ST_LOAD;
				end
				binom_pkg::ST_LOAD: begin
					state_q <= binom_pkg::ST_RESULT;
				end
				binom_pkg::ST_RESULT: begin
					if (out_load) begin
						state_q <= binom_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= binom_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// output register, stable while the transaction waits
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= res_q;
		end
	end

	// query, row counters and result
	always_ff @(posedge clk) begin
		case (state_q)
			binom_pkg::ST_IDLE: begin
				n_q <= s_tdata[9:0];
				k_q <= s_tdata[19:10];
				i_q <= NW'(2);
				r_q <= '0;
				if (s_tdata[19:10] > s_tdata[9:0]
					|| 32'(s_tdata[9:0]) > 32'(MAX_N)) begin
					res_q <= '0;
				end else begin
					res_q <= CW'(1);
				end
			end
			binom_pkg::ST_SWEEP: begin
				if (r_q == '0) begin
					// next row starts one entry higher
					i_q <= i_q + NW'(1);
					r_q <= i_q - NW'(1);
				end else begin
					r_q <= r_q - NW'(1);
				end
			end
			binom_pkg::ST_LOAD: begin
				res_q <= rd_val;
			end
			default: begin
			end
		endcase
	end

	// entry 0 and entries at or above n, the edge of the last row, are never written back
	a_no_edge_write: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> (idx_s1 != '0 && idx_s1 < n_q))
		else $error("write-back to an edge entry");

	// sweep read index stays inside the current row
	a_sweep_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == binom_pkg::ST_SWEEP |-> ({1'b0, r_q} + (NW+1)'(2) <= {1'b0, i_q}
			&& i_q <= n_q))
		else $error("sweep index out of row");

	// a bypass is only ever consumed by the sweep or the final lookup
	a_fwd_use: assert property (@(posedge clk) disable iff (!arst_n)
		fwd_s1 |-> (v_s1 || state_q == binom_pkg::ST_LOAD))
		else $error("unexpected read/write collision");

	// a result leaves the sequencer once the output slot is free
	a_result_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == binom_pkg::ST_RESULT && (!m_tvalid || m_tready))
		|=> (m_tvalid && state_q == binom_pkg::ST_IDLE))
		else $error("result not presented");

endmodule

// File: sim/binomial_coefficient_mod_prime_top_test.sv
`timescale 1ns / 100ps

// Stream testbench for the Pascal-rule binomial block.
// Queries (n, k) go in on the slave side; every accepted transaction gets its
// coefficient worked out here by rebuilding a row in place, just as the block
// does, and is queued. Results on the master side are popped in order and
// compared. The sender works in bursts, the receiver stalls in phases.
module binomial_coefficient_mod_prime_top_test;

	localparam int unsigned        N_W            = binom_pkg::N_W;
	localparam int unsigned        COEF_W         = binom_pkg::COEF_W;

	localparam int unsigned        ROW_MAX        = 1023;
	localparam logic [COEF_W:0]    MODULUS        = 31'd1000000007;
	// slowest query: a full sweep at n = 1023, plus stalls
	localparam int unsigned        WATCHDOG_LIMIT = 2_200_000;
	localparam int unsigned        DRAIN_CYCLES   = 16;
	localparam int unsigned        RANDOM_QUERIES = 80;

	// receiver behaviour, one phase at a time
	typedef enum logic [1:0] {
		RX_FLOW,
		RX_RANDOM,
		RX_STALL
	} rx_mode_t;

	logic              clk;
	logic              arst_n   = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [23:0]       s_tdata  = '0;    // [9:0] row_n, [19:10] choose_k, rest zero
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [31:0]       m_tdata;          // [29:0] coefficient, rest zero

	logic [COEF_W-1:0] expected_coefs[$];
	int unsigned       queries_sent;
	int unsigned       results_checked;
	int unsigned       mismatches;
	int unsigned       widest_row;
	int unsigned       burst_left;
	int unsigned       idle_cycles;
	int unsigned       rx_left;
	rx_mode_t          rx_mode;

	binomial_coefficient_mod_prime_top u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// C(n, k) mod prime: one row rebuilt in place, downward sweep,
	// add then a single conditional subtract
	function automatic logic [COEF_W-1:0] pascal_mod(input logic [N_W-1:0] n,
		input logic [N_W-1:0] k);
		logic [COEF_W-1:0] row [0:ROW_MAX];
		logic [COEF_W:0]   sum;
		int                i;
		int                j;
		if (k > n) begin
			return '0;
		end
		row[0] = COEF_W'(1);
		for (i = 1; i <= int'(n); i++) begin
			row[i] = COEF_W'(1);
			for (j = i - 1; j >= 1; j--) begin
				sum = {1'b0, row[j]} + {1'b0, row[j-1]};
				if (sum >= MODULUS) begin
					sum = sum - MODULUS;
				end
				row[j] = sum[COEF_W-1:0];
			end
		end
		return row[k];
	endfunction

	// Send one query; gaps only fall between bursts. Valid is never dropped
	// and raised in the same step: a back-to-back item just overwrites data.
	task automatic send_query(input logic [N_W-1:0] n, input logic [N_W-1:0] k);
		int unsigned gap;
		gap = 0;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			// a quarter of the bursts start with no gap at all
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
		end
		burst_left--;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {4'b0, k, n};
		do @(posedge clk); while (!s_tready);
		expected_coefs = {expected_coefs, pascal_mod(n, k)};
		queries_sent++;
		// only queries with 1 <= k < n actually sweep rows
		if (k != 0 && k < n && int'(n) > widest_row) begin
			widest_row = 32'(n);
		end
	endtask

	// k = 0 and k = n at the extremes of n, including n = 0
	task automatic test_edge_entries();
		send_query(10'd0, 10'd0);
		send_query(10'd1, 10'd0);
		send_query(10'd1, 10'd1);
		send_query(10'd5, 10'd0);
		send_query(10'd5, 10'd5);
		send_query(10'd1023, 10'd0);
		send_query(10'd1023, 10'd1023);
	endtask

	// k above n gives zero and skips the sweep
	task automatic test_k_above_n();
		send_query(10'd0, 10'd1);
		send_query(10'd3, 10'd4);
		send_query(10'd10, 10'd1023);
		send_query(10'd512, 10'd513);
		send_query(10'd1022, 10'd1023);
	endtask

	// short rows, values well below the prime
	task automatic test_small_rows();
		send_query(10'd2, 10'd1);
		send_query(10'd4, 10'd2);
		send_query(10'd6, 10'd3);
		send_query(10'd10, 10'd5);
		send_query(10'd30, 10'd15);
	endtask

	// from row 33 on the centre entries pass the prime, so the subtract fires
	task automatic test_modular_wrap();
		send_query(10'd34, 10'd17);
		send_query(10'd40, 10'd20);
		send_query(10'd60, 10'd31);
		send_query(10'd100, 10'd50);
		send_query(10'd200, 10'd199);
	endtask

	// one full-depth sweep: the most expensive query the block accepts
	task automatic test_largest_row();
		send_query(10'd1023, 10'd512);
	endtask

	// mostly short sweeps, some longer ones, and cheap queries across the
	// whole field range so every bit of n and k toggles
	task automatic test_random_queries();
		logic [N_W-1:0] n;
		logic [N_W-1:0] k;
		int unsigned    pick;
		repeat (RANDOM_QUERIES) begin
			pick = $urandom_range(0, 99);
			if (pick < 70) begin
				n = N_W'($urandom_range(0, 63));
				if ($urandom_range(0, 4) != 0) begin
					k = N_W'($urandom_range(0, n));
				end else begin
					k = N_W'($urandom_range(0, 1023));
				end
			end else if (pick < 82) begin
				n = N_W'($urandom_range(64, 200));
				k = N_W'($urandom_range(1, n - 1));
			end else if (pick < 92) begin
				n = N_W'($urandom_range(0, 1023));
				k = $urandom_range(0, 1) ? n : '0;
			end else begin
				n = N_W'($urandom_range(0, 1022));
				k = N_W'($urandom_range(n + 1, 1023));
			end
			send_query(n, k);
		end
	endtask

	// Result checker plus receiver stall pattern. Outputs are read as they
	// stood before the edge; tready is updated by a single NBA per edge.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_coefs.size() == 0) begin
				$error("coefficient: no transaction expected, got %0d",
					m_tdata[COEF_W-1:0]);
				mismatches++;
			end else begin
				if (m_tdata[COEF_W-1:0] !== expected_coefs[0]) begin
					$error("coefficient: expected %0d, got %0d", expected_coefs[0],
						m_tdata[COEF_W-1:0]);
					mismatches++;
				end
				void'(expected_coefs.pop_front());
				results_checked++;
			end
		end
		if (rx_left == 0) begin
			rx_mode = rx_mode_t'($urandom_range(0, 2));
			rx_left = $urandom_range(1, 40);
		end else begin
			rx_left--;
		end
		case (rx_mode)
			RX_FLOW: begin
				m_tready <= 1'b1;
			end
			RX_RANDOM: begin
				m_tready <= 1'($urandom_range(0, 1));
			end
			default: begin
				m_tready <= 1'b0;
			end
		endcase
	end

	// watchdog: cycles without any transaction on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	initial begin
		queries_sent    = 0;
		results_checked = 0;
		mismatches      = 0;
		widest_row      = 0;
		burst_left      = 0;
		idle_cycles     = 0;
		rx_left         = 0;
		rx_mode         = RX_FLOW;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_edge_entries();
		test_k_above_n();
		test_small_rows();
		test_modular_wrap();
		test_largest_row();
		test_random_queries();
		s_tvalid <= 1'b0;

		// drain, then a few cycles to catch anything spurious
		while (expected_coefs.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d queries sent, %0d coefficients checked, widest row swept n=%0d",
			queries_sent, results_checked, widest_row);
		$display("covered: edge entries, k above n, modular wrap, full-depth row, random mix");
		if (mismatches == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
